// ----- hdl/jcr_pkg.sv -----
// Shared types, constants and the CRC-8 step for the controller bus responder.
`timescale 1ns / 1ps
package jcr_pkg;

  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned IDX_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUT_EN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_CRC     = 2'd3;

  localparam logic [31:0] DISCONNECT_RESET = 32'd4000000;
  localparam logic [31:0] SHUTDOWN_RESET   = 32'd8000000;
  localparam logic [7:0]  ID_CRC_RESET     = 8'hB8;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_REPORT = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [7:0] CMD_PROBE = 8'h00;
  localparam logic [7:0] CMD_POLL  = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h02;
  localparam logic [7:0] CMD_WRITE = 8'h03;
  localparam logic [7:0] CMD_RESET = 8'hFF;

  localparam logic [7:0]  ADDR_LOW_MASK = 8'hE0;
  localparam logic [15:0] ADDR_IDENTIFY = 16'h8000;
  localparam logic [15:0] ADDR_RUMBLE   = 16'hC000;
  localparam logic [7:0]  CRC_POLY      = 8'h85;
  localparam logic [7:0]  ID_FILL       = 8'h80;
  localparam logic [7:0]  PROBE_B0      = 8'h05;
  localparam logic [7:0]  PROBE_B1      = 8'h00;
  localparam logic [7:0]  PROBE_B2      = 8'h01;

  localparam logic [IDX_W-1:0] PROBE_LAST = 6'd2;
  localparam logic [IDX_W-1:0] POLL_LAST  = 6'd3;
  localparam logic [IDX_W-1:0] READ_LAST  = 6'd32;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_READ  = 2'd2,
    RX_WRITE = 2'd3
  } rx_mode_t;

  typedef enum logic [2:0] {
    JOB_PROBE,
    JOB_POLL,
    JOB_RD_ID,
    JOB_RD_ZERO,
    JOB_WR,
    JOB_STAT
  } job_op_t;

  typedef struct packed {
    logic connected;
    logic rumble_on;
    logic shutdown_request;
  } stat_t;

  typedef struct packed {
    job_op_t     op;
    logic [31:0] data;
    stat_t       flags;
  } job_t;

  typedef struct packed {
    logic [31:0] disconnect_ticks;
    logic [31:0] shutdown_ticks;
    logic        shutdown_enable;
    logic [7:0]  identify_crc;
  } cfg_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] x;
    x = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

// ----- hdl/jcr_front.sv -----
// Request decoder: command state, pak transfers, report store and idle timer.
`timescale 1ns / 1ps
module jcr_front
  import jcr_pkg::*;
#(
  parameter int unsigned MESSAGE_LAST_INDEX = 33,
  parameter int unsigned IDLE_COUNTER_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic [7:0] buttons_hi,
  input  logic [7:0] buttons_lo,
  input  logic [7:0] stick_x,
  input  logic [7:0] stick_y,
  input  cfg_t       cfg,
  output logic       push,
  output job_t       push_job
);

  localparam int unsigned CMP_W = (IDLE_COUNTER_WIDTH > 32) ? IDLE_COUNTER_WIDTH : 32;
  localparam logic [IDX_W-1:0] WR_LAST = IDX_W'(MESSAGE_LAST_INDEX);

  rx_mode_t                      mode_r, mode_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [7:0]                    addr_hi_r, addr_hi_nxt;
  logic [7:0]                    addr_lo_r, addr_lo_nxt;
  logic [7:0]                    first_r, first_nxt;
  logic [7:0]                    crc_r, crc_nxt;
  logic                          rumble_r, rumble_nxt;
  logic [31:0]                   report_r, report_nxt;
  logic                          link_r, link_nxt;
  logic [IDLE_COUNTER_WIDTH-1:0] idle_r, idle_nxt, idle_inc;
  logic                          shut_r, shut_nxt;

  logic       is_byte;
  logic [7:0] crc_step;
  logic       rd_id_hit;
  logic       wr_rumble_hit;
  logic       wr_done;

  assign is_byte       = accept && (req_type == REQ_BYTE);
  assign crc_step      = crc8_step(crc_r, rx_byte);
  assign rd_id_hit     = ({addr_hi_r, rx_byte & ADDR_LOW_MASK} == ADDR_IDENTIFY);
  assign wr_rumble_hit = ({addr_hi_r, addr_lo_r & ADDR_LOW_MASK} == ADDR_RUMBLE);
  assign wr_done       = (idx_r >= WR_LAST);
  assign idle_inc      = (&idle_r) ? idle_r : idle_r + 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (is_byte) begin
      case (mode_r)
        RX_READ: begin
          if (idx_r != '0) mode_nxt = RX_IDLE;
        end
        RX_WRITE: begin
          if (wr_done) mode_nxt = RX_IDLE;
        end
        RX_IDLE: begin
          if (rx_byte == CMD_READ) mode_nxt = RX_READ;
          else if (rx_byte == CMD_WRITE) mode_nxt = RX_WRITE;
        end
        default: mode_nxt = RX_IDLE;
      endcase
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    first_nxt   = first_r;
    crc_nxt     = crc_r;
    rumble_nxt  = rumble_r;
    report_nxt  = report_r;
    link_nxt    = link_r;
    idle_nxt    = idle_r;
    shut_nxt    = shut_r;
    push        = 1'b0;
    push_job    = '0;
    if (accept) begin
      case (req_type)
        REQ_BYTE: begin
          case (mode_r)
            RX_READ: begin
              if (idx_r == '0) begin
                addr_hi_nxt = rx_byte;
                idx_nxt     = IDX_W'(1);
              end else begin
                addr_lo_nxt   = rx_byte;
                idx_nxt       = '0;
                push          = 1'b1;
                push_job.op   = rd_id_hit ? JOB_RD_ID : JOB_RD_ZERO;
                push_job.data = {24'd0, cfg.identify_crc};
              end
            end
            RX_WRITE: begin
              if (idx_r == IDX_W'(0)) addr_hi_nxt = rx_byte;
              else if (idx_r == IDX_W'(1)) addr_lo_nxt = rx_byte;
              else if (idx_r == IDX_W'(2)) first_nxt = rx_byte;
              if (idx_r > IDX_W'(1)) crc_nxt = crc_step;
              if (wr_done) begin
                if (wr_rumble_hit) rumble_nxt = (first_r != '0);
                idx_nxt       = '0;
                push          = 1'b1;
                push_job.op   = JOB_WR;
                push_job.data = {24'd0, crc_nxt};
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            default: begin
              case (rx_byte)
                CMD_PROBE, CMD_RESET: begin
                  push        = 1'b1;
                  push_job.op = JOB_PROBE;
                end
                CMD_POLL: begin
                  link_nxt      = 1'b1;
                  idle_nxt      = '0;
                  push          = 1'b1;
                  push_job.op   = JOB_POLL;
                  push_job.data = report_r;
                end
                CMD_READ, CMD_WRITE: begin
                  crc_nxt = '0;
                  idx_nxt = '0;
                end
                default: ;
              endcase
            end
          endcase
        end
        REQ_REPORT: begin
          report_nxt = {buttons_hi, buttons_lo, stick_x, stick_y};
        end
        REQ_TICK: begin
          idle_nxt = idle_inc;
          if (link_r && (CMP_W'(idle_inc) >= CMP_W'(cfg.disconnect_ticks))) link_nxt = 1'b0;
          if (cfg.shutdown_enable && (CMP_W'(idle_inc) >= CMP_W'(cfg.shutdown_ticks))) begin
            shut_nxt = 1'b1;
          end
          push        = 1'b1;
          push_job.op = JOB_STAT;
        end
        default: ;
      endcase
    end
    push_job.flags.connected        = link_nxt;
    push_job.flags.rumble_on        = rumble_nxt;
    push_job.flags.shutdown_request = shut_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RX_IDLE;
      idx_r    <= '0;
      crc_r    <= '0;
      rumble_r <= 1'b0;
      report_r <= '0;
      link_r   <= 1'b0;
      idle_r   <= '0;
      shut_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      rumble_r <= rumble_nxt;
      report_r <= report_nxt;
      link_r   <= link_nxt;
      idle_r   <= idle_nxt;
      shut_r   <= shut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_hi_r <= addr_hi_nxt;
    addr_lo_r <= addr_lo_nxt;
    first_r   <= first_nxt;
  end

endmodule

// ----- hdl/jcr_queue.sv -----
// Small job queue between the request decoder and the reply sequencer.
`timescale 1ns / 1ps
module jcr_queue
  import jcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign avail = (count_r != '0);
  assign head  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= push_job;
  end

endmodule

// ----- hdl/jcr_back.sv -----
// Reply sequencer: expands queued jobs into result bytes behind an output register.
`timescale 1ns / 1ps
module jcr_back
  import jcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_avail,
  input  job_t       job_head,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  output stat_t      out_flags
);

  job_t             cur_r, cur_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic             kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  stat_t            flags_r, flags_nxt;

  logic             out_free;
  logic             emit;
  logic [7:0]       gen_byte;
  logic             gen_end;
  logic             gen_kind;

  assign out_free = !ov_r || out_ready;
  assign emit     = cur_vld_r && out_free;
  assign job_pop  = job_avail && (!cur_vld_r || (emit && gen_end));

  always_comb begin
    gen_byte = '0;
    gen_end  = 1'b1;
    gen_kind = 1'b0;
    case (cur_r.op)
      JOB_PROBE: begin
        gen_end = (idx_r == PROBE_LAST);
        if (idx_r == '0) gen_byte = PROBE_B0;
        else if (idx_r == IDX_W'(1)) gen_byte = PROBE_B1;
        else gen_byte = PROBE_B2;
      end
      JOB_POLL: begin
        gen_end = (idx_r == POLL_LAST);
        case (idx_r[1:0])
          2'd0:    gen_byte = cur_r.data[31:24];
          2'd1:    gen_byte = cur_r.data[23:16];
          2'd2:    gen_byte = cur_r.data[15:8];
          default: gen_byte = cur_r.data[7:0];
        endcase
      end
      JOB_RD_ID: begin
        gen_end  = (idx_r == READ_LAST);
        gen_byte = gen_end ? cur_r.data[7:0] : ID_FILL;
      end
      JOB_RD_ZERO: begin
        gen_end = (idx_r == READ_LAST);
      end
      JOB_WR: begin
        gen_byte = cur_r.data[7:0];
      end
      JOB_STAT: begin
        gen_kind = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    ov_nxt      = ov_r && !out_ready;
    kind_nxt    = kind_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    flags_nxt   = flags_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      kind_nxt  = gen_kind;
      byte_nxt  = gen_byte;
      last_nxt  = gen_end && !gen_kind;
      flags_nxt = cur_r.flags;
      if (gen_end) begin
        cur_vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (job_pop) begin
      cur_nxt     = job_head;
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      ov_r      <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      ov_r      <= ov_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    flags_r <= flags_nxt;
  end

  assign out_valid   = ov_r;
  assign out_kind    = kind_r;
  assign out_tx_byte = byte_r;
  assign out_tx_last = last_r;
  assign out_flags   = flags_r;

endmodule

// ----- hdl/joybus_controller_responder_top.sv -----
// Top level of the controller bus responder: configuration registers and block wiring.
// Each request (received bus byte, report update or microsecond tick) is decoded in the
// cycle it is accepted, so requests may arrive every cycle while the job queue has room.
// Replies leave one byte per cycle, while out_ready is high, from the sequencer's output
// register: probe and reset give 3 bytes, poll 4, pak read 33, the end of a pak write 1,
// and each tick one status result. While a pak read reply occupies the output, requests
// keep being taken until the 4-entry job queue fills behind it.
`timescale 1ns / 1ps
module joybus_controller_responder_top
  import jcr_pkg::*;
#(
  parameter int unsigned MESSAGE_LAST_INDEX = 33,
  parameter int unsigned IDLE_COUNTER_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [7:0]           in_rx_byte,
  input  logic [7:0]           in_buttons_hi,
  input  logic [7:0]           in_buttons_lo,
  input  logic [7:0]           in_stick_x,
  input  logic [7:0]           in_stick_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [7:0]           out_tx_byte,
  output logic                 out_tx_last,
  output logic                 out_connected,
  output logic                 out_rumble_on,
  output logic                 out_shutdown_request,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full;
  logic  q_avail;
  logic  q_pop;
  logic  push;
  job_t  push_job;
  job_t  head;
  stat_t flags;
  logic  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DISCONNECT: cfg_nxt.disconnect_ticks = cfg_wdata;
        CFG_SHUTDOWN:   cfg_nxt.shutdown_ticks   = cfg_wdata;
        CFG_SHUT_EN:    cfg_nxt.shutdown_enable  = cfg_wdata[0];
        CFG_ID_CRC:     cfg_nxt.identify_crc     = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disconnect_ticks <= DISCONNECT_RESET;
      cfg_r.shutdown_ticks   <= SHUTDOWN_RESET;
      cfg_r.shutdown_enable  <= 1'b0;
      cfg_r.identify_crc     <= ID_CRC_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jcr_front #(
    .MESSAGE_LAST_INDEX(MESSAGE_LAST_INDEX),
    .IDLE_COUNTER_WIDTH(IDLE_COUNTER_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .rx_byte   (in_rx_byte),
    .buttons_hi(in_buttons_hi),
    .buttons_lo(in_buttons_lo),
    .stick_x   (in_stick_x),
    .stick_y   (in_stick_y),
    .cfg       (cfg_r),
    .push      (push),
    .push_job  (push_job)
  );

  jcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .avail   (q_avail),
    .head    (head)
  );

  jcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (q_avail),
    .job_head   (head),
    .job_pop    (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_tx_byte(out_tx_byte),
    .out_tx_last(out_tx_last),
    .out_flags  (flags)
  );

  assign out_connected        = flags.connected;
  assign out_rumble_on        = flags.rumble_on;
  assign out_shutdown_request = flags.shutdown_request;

endmodule

// ----- dv/tb_joybus_controller_responder_top.sv -----
// Self-checking testbench for the controller bus responder: directed, random and stall traffic.
`timescale 1ns / 1ps
module tb_joybus_controller_responder_top;
  import jcr_pkg::*;

  localparam int unsigned LAST_BYTE_INDEX = 33;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          END_CYCLES      = 50;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int          PRINT_CAP       = 60;
  localparam logic [1:0]  REQ_UNUSED      = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] rx;
    logic [7:0] b_hi;
    logic [7:0] b_lo;
    logic [7:0] sx;
    logic [7:0] sy;
  } bus_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       connected;
    logic       rumble_on;
    logic       shutdown;
  } reply_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_req_type;
  logic [7:0]           in_rx_byte;
  logic [7:0]           in_buttons_hi;
  logic [7:0]           in_buttons_lo;
  logic [7:0]           in_stick_x;
  logic [7:0]           in_stick_y;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_kind;
  logic [7:0]           out_tx_byte;
  logic                 out_tx_last;
  logic                 out_connected;
  logic                 out_rumble_on;
  logic                 out_shutdown_request;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  joybus_controller_responder_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_rx_byte           (in_rx_byte),
    .in_buttons_hi        (in_buttons_hi),
    .in_buttons_lo        (in_buttons_lo),
    .in_stick_x           (in_stick_x),
    .in_stick_y           (in_stick_y),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_tx_byte          (out_tx_byte),
    .out_tx_last          (out_tx_last),
    .out_connected        (out_connected),
    .out_rumble_on        (out_rumble_on),
    .out_shutdown_request (out_shutdown_request),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // Expected replies and the responder state that produces them
  reply_t      replies_due[$];
  cfg_t        settings;
  rx_mode_t    pak_mode;
  logic [5:0]  pak_index;
  logic [7:0]  pak_addr_hi;
  logic [7:0]  pak_addr_lo;
  logic [7:0]  pak_first_data;
  logic [7:0]  pak_crc;
  logic        rumble;
  logic        link_up;
  logic        shutdown;
  logic [31:0] report;
  logic [31:0] idle_ticks;

  int          failures = 0;
  int          replies_seen = 0;
  int          requests_taken = 0;
  int unsigned cycle_count = 0;
  bit          feed_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int          hold_off_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic log_failure(input string msg);
    if (failures < PRINT_CAP) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    failures++;
  endtask

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic reset_model();
    settings.disconnect_ticks = DISCONNECT_RESET;
    settings.shutdown_ticks   = SHUTDOWN_RESET;
    settings.shutdown_enable  = 1'b0;
    settings.identify_crc     = ID_CRC_RESET;
    pak_mode       = RX_IDLE;
    pak_index      = '0;
    pak_addr_hi    = '0;
    pak_addr_lo    = '0;
    pak_first_data = '0;
    pak_crc        = '0;
    rumble         = 1'b0;
    link_up        = 1'b0;
    shutdown       = 1'b0;
    report         = '0;
    idle_ticks     = '0;
  endtask

  task automatic queue_reply(input logic kind, input logic [7:0] b, input logic last);
    reply_t r;
    r.kind      = kind;
    r.tx_byte   = b;
    r.tx_last   = last;
    r.connected = link_up;
    r.rumble_on = rumble;
    r.shutdown  = shutdown;
    replies_due.push_back(r);
  endtask

  task automatic take_bus_byte(input logic [7:0] b);
    logic hit;
    if (pak_mode == RX_READ) begin
      if (pak_index == 0) begin
        pak_addr_hi = b;
        pak_index   = 6'd1;
      end else begin
        pak_addr_lo = b;
        pak_mode    = RX_IDLE;
        pak_index   = '0;
        hit = ({pak_addr_hi, pak_addr_lo & ADDR_LOW_MASK} == ADDR_IDENTIFY);
        for (int i = 0; i < 32; i++) begin
          queue_reply(1'b0, hit ? ID_FILL : 8'h00, 1'b0);
        end
        queue_reply(1'b0, hit ? settings.identify_crc : 8'h00, 1'b1);
      end
    end else if (pak_mode == RX_WRITE) begin
      if (pak_index == 0) begin
        pak_addr_hi = b;
      end else if (pak_index == 1) begin
        pak_addr_lo = b;
      end else if (pak_index == 2) begin
        pak_first_data = b;
      end
      if (pak_index > 1) begin
        pak_crc = crc8_next(pak_crc, b);
      end
      if (pak_index >= LAST_BYTE_INDEX) begin
        if ({pak_addr_hi, pak_addr_lo & ADDR_LOW_MASK} == ADDR_RUMBLE) begin
          rumble = (pak_first_data != 0);
        end
        pak_mode  = RX_IDLE;
        pak_index = '0;
        queue_reply(1'b0, pak_crc, 1'b1);
      end else begin
        pak_index = pak_index + 6'd1;
      end
    end else begin
      case (b)
        CMD_PROBE, CMD_RESET: begin
          queue_reply(1'b0, PROBE_B0, 1'b0);
          queue_reply(1'b0, PROBE_B1, 1'b0);
          queue_reply(1'b0, PROBE_B2, 1'b1);
        end
        CMD_POLL: begin
          link_up    = 1'b1;
          idle_ticks = '0;
          queue_reply(1'b0, report[31:24], 1'b0);
          queue_reply(1'b0, report[23:16], 1'b0);
          queue_reply(1'b0, report[15:8], 1'b0);
          queue_reply(1'b0, report[7:0], 1'b1);
        end
        CMD_READ: begin
          pak_crc   = '0;
          pak_mode  = RX_READ;
          pak_index = '0;
        end
        CMD_WRITE: begin
          pak_crc   = '0;
          pak_mode  = RX_WRITE;
          pak_index = '0;
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic predict_replies(input bus_req_t r);
    case (r.req)
      REQ_BYTE: begin
        take_bus_byte(r.rx);
      end
      REQ_REPORT: begin
        report = {r.b_hi, r.b_lo, r.sx, r.sy};
      end
      REQ_TICK: begin
        if (idle_ticks != '1) begin
          idle_ticks = idle_ticks + 1;
        end
        if (link_up && idle_ticks >= settings.disconnect_ticks) begin
          link_up = 1'b0;
        end
        if (settings.shutdown_enable && idle_ticks >= settings.shutdown_ticks) begin
          shutdown = 1'b1;
        end
        queue_reply(1'b1, 8'h00, 1'b0);
      end
      default: begin
      end
    endcase
    if (r.req != REQ_UNUSED) begin
      requests_taken++;
    end
  endtask

  task automatic send_request(input bus_req_t r);
    int gap;
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= r.req;
    in_rx_byte    <= r.rx;
    in_buttons_hi <= r.b_hi;
    in_buttons_lo <= r.b_lo;
    in_stick_x    <= r.sx;
    in_stick_y    <= r.sy;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_replies(r);
  endtask

  function automatic bus_req_t make_request(input logic [1:0] req, input logic [7:0] rx);
    bus_req_t r;
    r.req  = req;
    r.rx   = rx;
    r.b_hi = 8'($urandom_range(0, 255));
    r.b_lo = 8'($urandom_range(0, 255));
    r.sx   = 8'($urandom_range(0, 255));
    r.sy   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    send_request(make_request(REQ_BYTE, b));
  endtask

  task automatic send_tick();
    send_request(make_request(REQ_TICK, 8'($urandom_range(0, 255))));
  endtask

  task automatic send_report(input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] x, input logic [7:0] y);
    bus_req_t r;
    r      = make_request(REQ_REPORT, 8'($urandom_range(0, 255)));
    r.b_hi = hi;
    r.b_lo = lo;
    r.sx   = x;
    r.sy   = y;
    send_request(r);
  endtask

  task automatic pak_read(input logic [7:0] hi, input logic [7:0] lo, input bit ticks);
    send_byte(CMD_READ);
    send_byte(hi);
    if (ticks) begin
      send_tick();
    end
    send_byte(lo);
  endtask

  task automatic pak_write(input logic [7:0] hi, input logic [7:0] lo,
                           input logic [7:0] first, input bit ticks);
    send_byte(CMD_WRITE);
    send_byte(hi);
    send_byte(lo);
    send_byte(first);
    for (int i = 1; i < 32; i++) begin
      if (ticks && $urandom_range(0, 7) == 0) begin
        send_tick();
      end
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Drop valid and hold until every expected reply has left
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DISCONNECT: settings.disconnect_ticks = val;
      CFG_SHUTDOWN:   settings.shutdown_ticks = val;
      CFG_SHUT_EN:    settings.shutdown_enable = val[0];
      CFG_ID_CRC:     settings.identify_crc = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] disc, input logic [31:0] shut,
                                input logic en, input logic [7:0] id_crc);
    drain_replies();
    write_reg(CFG_DISCONNECT, disc);
    write_reg(CFG_SHUTDOWN, shut);
    write_reg(CFG_SHUT_EN, ($urandom & 32'hFFFF_FFFE) | {31'd0, en});
    write_reg(CFG_ID_CRC, ($urandom & 32'hFFFF_FF00) | {24'd0, id_crc});
    cfg_we <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      log_failure($sformatf("reply %0d %s: got %h, expected %h", replies_seen, name, got,
                            want));
    end
  endtask

  initial begin : reply_checker
    reply_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          log_failure($sformatf("reply %0d arrived with nothing expected", replies_seen));
        end else begin
          want = replies_due.pop_front();
          compare_field("kind", {7'd0, out_kind}, {7'd0, want.kind});
          compare_field("tx_byte", out_tx_byte, want.tx_byte);
          compare_field("tx_last", {7'd0, out_tx_last}, {7'd0, want.tx_last});
          compare_field("connected", {7'd0, out_connected}, {7'd0, want.connected});
          compare_field("rumble_on", {7'd0, out_rumble_on}, {7'd0, want.rumble_on});
          compare_field("shutdown_request", {7'd0, out_shutdown_request},
                        {7'd0, want.shutdown});
        end
        replies_seen++;
      end
    end
  end

  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left = hold_off_left - 1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 19);
        end
      end
    end
  end

  task automatic test_identity();
    send_byte(CMD_PROBE);
    send_byte(CMD_RESET);
  endtask

  task automatic test_poll_report();
    send_byte(CMD_POLL);
    send_report(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_byte(CMD_POLL);
    send_report(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h80, 8'h7F);
    send_byte(CMD_POLL);
  endtask

  task automatic test_pak_read();
    pak_read(8'h80, 8'h1F, 1'b0);
    pak_read(8'h80, 8'h20, 1'b1);
  endtask

  task automatic test_pak_write();
    pak_write(8'hC0, 8'h1F, 8'h01, 1'b0);
    pak_write(8'hC0, 8'h20, 8'h00, 1'b1);
  endtask

  task automatic test_ignored_input();
    send_byte(8'h04);
    send_byte(8'hFE);
    send_request(make_request(REQ_UNUSED, CMD_PROBE));
    send_request(make_request(REQ_UNUSED, CMD_READ));
    send_byte(CMD_PROBE);
  endtask

  task automatic test_link_timeout();
    apply_settings(32'd1, SHUTDOWN_RESET, 1'b0, ID_CRC_RESET);
    send_byte(CMD_POLL);
    send_tick();
    send_tick();
    apply_settings(32'd3, SHUTDOWN_RESET, 1'b0, ID_CRC_RESET);
    send_byte(CMD_POLL);
    repeat (5) send_tick();
  endtask

  task automatic test_identify_crc_values();
    apply_settings(DISCONNECT_RESET, SHUTDOWN_RESET, 1'b0, 8'hFF);
    pak_read(8'h80, 8'h0A, 1'b0);
    apply_settings(DISCONNECT_RESET, SHUTDOWN_RESET, 1'b0, 8'($urandom_range(0, 255)));
    pak_read(8'h80, 8'h1F, 1'b1);
  endtask

  task automatic random_burst(input int count);
    int start;
    int pick;
    logic [7:0] hi;
    logic [7:0] lo;
    start = requests_taken;
    while (requests_taken - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_byte(pick < 6 ? CMD_PROBE : CMD_RESET);
      end else if (pick < 26) begin
        send_byte(CMD_POLL);
      end else if (pick < 38) begin
        send_report(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 52) begin
        repeat ($urandom_range(1, 6)) send_tick();
      end else if (pick < 66) begin
        hi = ($urandom_range(0, 1) == 0) ? ADDR_IDENTIFY[15:8] : 8'($urandom_range(0, 255));
        lo = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31)) :
                                           8'($urandom_range(0, 255));
        pak_read(hi, lo, $urandom_range(0, 3) == 0);
      end else if (pick < 82) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
        send_request(make_request(REQ_UNUSED, 8'($urandom_range(0, 255))));
      end else if (pick < 93) begin
        // broken read: command then address bytes split by ticks
        send_byte(CMD_READ);
        send_tick();
        send_byte(8'($urandom_range(0, 255)));
        send_tick();
        send_byte(8'($urandom_range(0, 255)));
      end else if (feed_gaps) begin
        drain_replies();
      end else begin
        send_byte(CMD_POLL);
      end
    end
  endtask

  task automatic test_random_traffic();
    apply_settings($urandom_range(1, 8), 32'hFFFF_FFFF, 1'b1, 8'($urandom_range(0, 255)));
    random_burst(12);
  endtask

  task automatic test_backpressure();
    drain_replies();
    hold_off_left <= 300;
    pak_read(8'h80, 8'h00, 1'b0);
    send_byte(CMD_PROBE);
    send_byte(CMD_POLL);
    repeat (4) send_tick();
    send_byte(CMD_RESET);
    drain_replies();
    hold_off_left <= 120;
    repeat (5) send_tick();
    send_byte(CMD_POLL);
    drain_replies();
  endtask

  task automatic test_shutdown();
    apply_settings(DISCONNECT_RESET, 32'd1, 1'b0, ID_CRC_RESET);
    send_byte(CMD_POLL);
    repeat (2) send_tick();
    apply_settings(DISCONNECT_RESET, 32'hFFFF_FFFF, 1'b1, ID_CRC_RESET);
    repeat (2) send_tick();
    apply_settings(32'd2, 32'd4, 1'b1, ID_CRC_RESET);
    send_byte(CMD_POLL);
    repeat (5) send_tick();
    send_byte(CMD_POLL);
    send_tick();
  endtask

  task automatic test_steady_stream();
    apply_settings($urandom_range(1, 10), 32'd1, 1'b0, 8'($urandom_range(0, 255)));
    random_burst(10);
  endtask

  initial begin : stimulus
    in_valid      <= 1'b0;
    in_req_type   <= REQ_BYTE;
    in_rx_byte    <= 8'h00;
    in_buttons_hi <= 8'h00;
    in_buttons_lo <= 8'h00;
    in_stick_x    <= 8'h00;
    in_stick_y    <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_DISCONNECT;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    drain_replies();

    test_identity();
    test_poll_report();
    test_pak_read();
    test_pak_write();
    test_ignored_input();
    test_link_timeout();
    test_identify_crc_values();
    test_random_traffic();
    test_backpressure();
    test_shutdown();
    feed_gaps   = 1'b0;
    sink_stalls = 1'b0;
    test_steady_stream();

    drain_replies();
    repeat (END_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      log_failure($sformatf("%0d expected replies never arrived", replies_due.size()));
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
